// ----- src/slrb_pkg.sv -----
// Shared types and codes for the stripe lane reassembly barrier.
package slrb_pkg;

  localparam int unsigned LANE_W  = 6;
  localparam int unsigned COUNT_W = 7;
  localparam int unsigned OP_W    = 4;
  localparam int unsigned PH_W    = 3;
  localparam int unsigned VERD_W  = 2;
  localparam int unsigned FLAG_W  = 3;

  // Opcodes, also used for the forwarded kind.
  localparam logic [OP_W-1:0] OP_DATA      = 4'd0;
  localparam logic [OP_W-1:0] OP_LOADED    = 4'd1;
  localparam logic [OP_W-1:0] OP_META      = 4'd2;
  localparam logic [OP_W-1:0] OP_INIT_FULL = 4'd3;
  localparam logic [OP_W-1:0] OP_INIT_INCR = 4'd4;
  localparam logic [OP_W-1:0] OP_FINI      = 4'd5;
  localparam logic [OP_W-1:0] OP_NEXT      = 4'd6;
  localparam logic [OP_W-1:0] OP_DONE      = 4'd7;
  localparam logic [OP_W-1:0] OP_ERROR     = 4'd8;
  localparam logic [OP_W-1:0] OP_FAIL      = 4'd9;
  localparam logic [OP_W-1:0] OP_SHUTDOWN  = 4'd10;

  // Stream phases.
  localparam logic [PH_W-1:0] PH_IDLE      = 3'd0;
  localparam logic [PH_W-1:0] PH_PROC      = 3'd1;
  localparam logic [PH_W-1:0] PH_FINISHING = 3'd2;
  localparam logic [PH_W-1:0] PH_ERROR     = 3'd3;
  localparam logic [PH_W-1:0] PH_SHUTDOWN  = 3'd4;

  // Verdicts.
  localparam logic [VERD_W-1:0] VERD_CONSUMED = 2'd0;
  localparam logic [VERD_W-1:0] VERD_DROPPED  = 2'd1;
  localparam logic [VERD_W-1:0] VERD_HELD     = 2'd2;

  // Stream flag bit positions.
  localparam int unsigned FL_FULL = 0;
  localparam int unsigned FL_ZSTD = 1;
  localparam int unsigned FL_MID  = 2;

  typedef struct packed {
    logic [LANE_W-1:0] lane_index;
    logic [OP_W-1:0]   opcode;
    logic              end_of_stripe;
    logic              from_file;
    logic              compressed;
    logic              frame_open;
  } slrb_item_t;

  typedef struct packed {
    logic [VERD_W-1:0] verdict;
    logic              pass_data;
    logic              forward_valid;
    logic [OP_W-1:0]   forward_kind;
    logic              decoder_reset;
    logic [PH_W-1:0]   stream_state;
    logic              fault;
  } slrb_result_t;

endpackage

// ----- src/slrb_rotate.sv -----
// Rotated find-first: next unfinished lane after the current one.
module slrb_rotate #(
  parameter int unsigned MAX_LANES = 64
) (
  input  logic [slrb_pkg::LANE_W-1:0]  cur_lane_i,
  input  logic [slrb_pkg::COUNT_W-1:0] active_lanes_i,
  input  logic [MAX_LANES-1:0]         finished_i,
  output logic [slrb_pkg::LANE_W-1:0]  next_lane_o
);
  import slrb_pkg::*;

  logic [MAX_LANES-1:0] unf;
  logic [MAX_LANES-1:0] above;
  logic [LANE_W-1:0]    first_above;
  logic [LANE_W-1:0]    first_any;

  always_comb begin
    for (int i = 0; i < MAX_LANES; i++) begin
      unf[i]   = !finished_i[i] && (COUNT_W'(i) < active_lanes_i);
      above[i] = LANE_W'(i) > cur_lane_i;
    end
  end

  // Scan from the top so that the lowest set bit wins.
  always_comb begin
    first_above = cur_lane_i;
    first_any   = cur_lane_i;
    for (int i = MAX_LANES - 1; i >= 0; i--) begin
      if (unf[i] && above[i]) begin
        first_above = LANE_W'(i);
      end
      if (unf[i]) begin
        first_any = LANE_W'(i);
      end
    end
  end

  assign next_lane_o = (|(unf & above)) ? first_above : first_any;

endmodule

// ----- src/slrb_ctrl.sv -----
// Per-fragment decision logic: verdict, barrier, rotation and stream phase.
module slrb_ctrl #(
  parameter int unsigned MAX_LANES = 64
) (
  input  slrb_pkg::slrb_item_t          item_i,
  input  logic [slrb_pkg::COUNT_W-1:0]  n_lanes_i,
  input  logic [slrb_pkg::PH_W-1:0]     phase_i,
  input  logic [slrb_pkg::LANE_W-1:0]   cur_lane_i,
  input  logic [slrb_pkg::COUNT_W-1:0]  active_i,
  input  logic [MAX_LANES-1:0]          finished_i,
  input  logic                          bar_valid_i,
  input  logic [slrb_pkg::OP_W-1:0]     bar_kind_i,
  input  logic [MAX_LANES-1:0]          bar_seen_i,
  input  logic [slrb_pkg::FLAG_W-1:0]   flags_i,
  output logic [slrb_pkg::PH_W-1:0]     phase_o,
  output logic [slrb_pkg::LANE_W-1:0]   cur_lane_o,
  output logic [slrb_pkg::COUNT_W-1:0]  active_o,
  output logic [MAX_LANES-1:0]          finished_o,
  output logic                          bar_valid_o,
  output logic [slrb_pkg::OP_W-1:0]     bar_kind_o,
  output logic [MAX_LANES-1:0]          bar_seen_o,
  output logic [slrb_pkg::FLAG_W-1:0]   flags_o,
  output slrb_pkg::slrb_result_t        result_o
);
  import slrb_pkg::*;

  localparam int unsigned LIDX_W = (MAX_LANES > 1) ? $clog2(MAX_LANES) : 1;

  logic [LANE_W-1:0]    lane;
  logic [OP_W-1:0]      op;
  logic [MAX_LANES-1:0] lane_oh;
  logic [MAX_LANES-1:0] n_mask;
  logic [MAX_LANES-1:0] fin_loaded;
  logic [MAX_LANES-1:0] fin_rot;
  logic [MAX_LANES-1:0] seen_new;
  logic [LANE_W-1:0]    rot_lane;
  logic                 multi;
  logic                 act;

  assign lane    = item_i.lane_index;
  assign op      = item_i.opcode;
  assign multi   = n_lanes_i != COUNT_W'(1);
  assign lane_oh = {{(MAX_LANES-1){1'b0}}, 1'b1} << lane;

  always_comb begin
    for (int i = 0; i < MAX_LANES; i++) begin
      n_mask[i] = COUNT_W'(i) < n_lanes_i;
    end
  end

  assign fin_loaded = finished_i | lane_oh;
  assign fin_rot    = (op == OP_LOADED) ? fin_loaded : finished_i;
  assign seen_new   = ((bar_valid_i && op == bar_kind_i) ? bar_seen_i : '0) | lane_oh;

  slrb_rotate #(
    .MAX_LANES(MAX_LANES)
  ) u_rotate (
    .cur_lane_i    (cur_lane_i),
    .active_lanes_i(active_i),
    .finished_i    (fin_rot),
    .next_lane_o   (rot_lane)
  );

  always_comb begin
    phase_o     = phase_i;
    cur_lane_o  = cur_lane_i;
    active_o    = active_i;
    finished_o  = finished_i;
    bar_valid_o = bar_valid_i;
    bar_kind_o  = bar_kind_i;
    bar_seen_o  = bar_seen_i;
    flags_o     = flags_i;
    result_o    = '0;
    act         = 1'b0;

    if (phase_i == PH_SHUTDOWN || op > OP_SHUTDOWN || {1'b0, lane} >= n_lanes_i) begin
      result_o.verdict = VERD_DROPPED;
      result_o.fault   = 1'b1;
    end else if (multi && phase_i == PH_ERROR && op != OP_FAIL) begin
      result_o.verdict = VERD_DROPPED;
    end else if (multi && op != OP_ERROR && bar_valid_i &&
                 bar_seen_i[lane[LIDX_W-1:0]]) begin
      result_o.verdict = VERD_HELD;
    end else if (multi && (op == OP_DATA || op == OP_LOADED) && lane != cur_lane_i) begin
      result_o.verdict = VERD_HELD;
    end else if (op == OP_DATA) begin
      if (phase_i != PH_ERROR &&
          (phase_i != PH_PROC || finished_i[lane[LIDX_W-1:0]])) begin
        result_o.verdict = VERD_DROPPED;
        result_o.fault   = 1'b1;
      end else begin
        if (phase_i != PH_ERROR) begin
          result_o.pass_data = 1'b1;
          flags_o[FL_MID]    = flags_i[FL_ZSTD] && item_i.frame_open;
        end
        if (item_i.end_of_stripe) begin
          cur_lane_o = rot_lane;
        end
      end
    end else if (op == OP_LOADED) begin
      if ({1'b0, lane} >= active_i) begin
        result_o.verdict = VERD_DROPPED;
        result_o.fault   = 1'b1;
      end else begin
        finished_o = fin_loaded;
        cur_lane_o = rot_lane;
      end
    end else if (!multi || op == OP_ERROR || op == OP_META) begin
      act = 1'b1;
    end else if (bar_valid_i && op != bar_kind_i && op != OP_FAIL) begin
      result_o.verdict = VERD_DROPPED;
      result_o.fault   = 1'b1;
    end else if ((seen_new & n_mask) == n_mask) begin
      // Last lane has arrived: release the barrier and act on the control.
      bar_valid_o = 1'b0;
      bar_kind_o  = OP_DATA;
      bar_seen_o  = '0;
      act         = 1'b1;
    end else begin
      bar_valid_o = 1'b1;
      bar_kind_o  = op;
      bar_seen_o  = seen_new;
    end

    if (act) begin
      result_o.decoder_reset = op != OP_META;
      if (phase_i != PH_ERROR || op == OP_FAIL) begin
        case (op) inside
          OP_META: begin
            result_o.forward_valid = 1'b1;
            result_o.forward_kind  = op;
          end
          OP_INIT_FULL, OP_INIT_INCR: begin
            if (phase_i != PH_IDLE) begin
              result_o.fault = 1'b1;
            end else begin
              phase_o          = PH_PROC;
              flags_o          = '0;
              flags_o[FL_FULL] = op == OP_INIT_FULL;
              flags_o[FL_ZSTD] = item_i.compressed;
              active_o         = item_i.from_file ? n_lanes_i : COUNT_W'(1);
              cur_lane_o       = '0;
              finished_o       = '0;
              result_o.forward_valid = 1'b1;
              result_o.forward_kind  = op;
            end
          end
          OP_FINI: begin
            if (phase_i != PH_PROC) begin
              result_o.fault = 1'b1;
            end else if (flags_i[FL_ZSTD] && flags_i[FL_MID]) begin
              phase_o = PH_ERROR;
              result_o.forward_valid = 1'b1;
              result_o.forward_kind  = OP_ERROR;
            end else begin
              phase_o = PH_FINISHING;
              result_o.forward_valid = 1'b1;
              result_o.forward_kind  = op;
            end
          end
          OP_NEXT, OP_DONE: begin
            if (phase_i != PH_FINISHING) begin
              result_o.fault = 1'b1;
            end else begin
              phase_o = PH_IDLE;
              result_o.forward_valid = 1'b1;
              result_o.forward_kind  = op;
            end
          end
          OP_ERROR: begin
            phase_o = PH_ERROR;
            result_o.forward_valid = 1'b1;
            result_o.forward_kind  = op;
          end
          OP_FAIL: begin
            phase_o    = PH_IDLE;
            active_o   = n_lanes_i;
            cur_lane_o = '0;
            finished_o = '0;
            result_o.forward_valid = 1'b1;
            result_o.forward_kind  = op;
          end
          OP_SHUTDOWN: begin
            if (phase_i != PH_IDLE) begin
              result_o.fault = 1'b1;
            end else begin
              phase_o = PH_SHUTDOWN;
              result_o.forward_valid = 1'b1;
              result_o.forward_kind  = op;
            end
          end
          default: begin
            result_o.fault = 1'b1;
          end
        endcase
      end
    end

    result_o.stream_state = phase_o;
  end

endmodule

// ----- src/stripe_lane_reassembly_barrier_core.sv -----
// Top level of the stripe lane reassembly barrier: registers, handshakes and state.
//
// Each fragment transfer on the input channel yields exactly one verdict transfer on the output
// channel, in order. The block takes one fragment every cycle while the output keeps up: a
// fragment lands in the input register, and once the result register is free or being emptied
// the decision logic (a rotated find-first over the finished-lane bitmap, the all-lanes-seen
// reduction of the barrier and the stream phase update) writes the verdict into the result
// register. The result register and the input register let a new fragment be taken while an
// earlier verdict still waits at the output. The lane count register is written through its
// own channel, which is always ready; a write clamps the count to one up to MAX_LANES, reloads
// the rotation and clears any open barrier, and is meant to be issued only while no fragment
// is in flight.
module stripe_lane_reassembly_barrier_core #(
  parameter int unsigned MAX_LANES = 64
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // Configuration channel.
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [slrb_pkg::COUNT_W-1:0]  cfg_lane_count_i,
  // Fragment channel.
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [slrb_pkg::LANE_W-1:0]   lane_index_i,
  input  logic [slrb_pkg::OP_W-1:0]     opcode_i,
  input  logic                          end_of_stripe_i,
  input  logic                          from_file_i,
  input  logic                          compressed_i,
  input  logic                          frame_open_i,
  // Verdict channel.
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [slrb_pkg::VERD_W-1:0]   verdict_o,
  output logic                          pass_data_o,
  output logic                          forward_valid_o,
  output logic [slrb_pkg::OP_W-1:0]     forward_kind_o,
  output logic                          decoder_reset_o,
  output logic [slrb_pkg::PH_W-1:0]     stream_state_o,
  output logic                          fault_o
);
  import slrb_pkg::*;

  // Input register.
  logic       in_vld_q;
  slrb_item_t item_q;

  // Result register.
  logic         out_vld_q;
  slrb_result_t res_q;

  // Block state.
  logic [COUNT_W-1:0]   n_lanes_q;
  logic [PH_W-1:0]      phase_q,    phase_d;
  logic [LANE_W-1:0]    cur_lane_q, cur_lane_d;
  logic [COUNT_W-1:0]   active_q,   active_d;
  logic [MAX_LANES-1:0] fin_q,      fin_d;
  logic                 bar_vld_q,  bar_vld_d;
  logic [OP_W-1:0]      bar_kind_q, bar_kind_d;
  logic [MAX_LANES-1:0] bar_seen_q, bar_seen_d;
  logic [FLAG_W-1:0]    flags_q,    flags_d;

  slrb_result_t res_d;
  logic         step;
  logic         cfg_write;
  logic [COUNT_W-1:0] cfg_n;

  // A fragment is decided when the result register is free or is being emptied this cycle.
  assign step        = in_vld_q && (!out_vld_q || out_ready_i);
  assign in_ready_o  = !in_vld_q || step;
  assign cfg_ready_o = 1'b1;
  assign cfg_write   = cfg_valid_i && cfg_ready_o;

  // Effective lane count: zero is taken as one, and anything beyond the lane budget saturates.
  always_comb begin
    if (cfg_lane_count_i == '0) begin
      cfg_n = COUNT_W'(1);
    end else if (cfg_lane_count_i > COUNT_W'(MAX_LANES)) begin
      cfg_n = COUNT_W'(MAX_LANES);
    end else begin
      cfg_n = cfg_lane_count_i;
    end
  end

  slrb_ctrl #(
    .MAX_LANES(MAX_LANES)
  ) u_ctrl (
    .item_i     (item_q),
    .n_lanes_i  (n_lanes_q),
    .phase_i    (phase_q),
    .cur_lane_i (cur_lane_q),
    .active_i   (active_q),
    .finished_i (fin_q),
    .bar_valid_i(bar_vld_q),
    .bar_kind_i (bar_kind_q),
    .bar_seen_i (bar_seen_q),
    .flags_i    (flags_q),
    .phase_o    (phase_d),
    .cur_lane_o (cur_lane_d),
    .active_o   (active_d),
    .finished_o (fin_d),
    .bar_valid_o(bar_vld_d),
    .bar_kind_o (bar_kind_d),
    .bar_seen_o (bar_seen_d),
    .flags_o    (flags_d),
    .result_o   (res_d)
  );

  // Input register: a new fragment is captured whenever the register is empty or advancing.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_ready_o) begin
      in_vld_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      item_q.lane_index    <= lane_index_i;
      item_q.opcode        <= opcode_i;
      item_q.end_of_stripe <= end_of_stripe_i;
      item_q.from_file     <= from_file_i;
      item_q.compressed    <= compressed_i;
      item_q.frame_open    <= frame_open_i;
    end
  end

  // Result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (step) begin
      out_vld_q <= 1'b1;
    end else if (out_ready_i) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step) begin
      res_q <= res_d;
    end
  end

  // State: a configuration write reloads the rotation and clears the barrier; otherwise
  // each decided fragment commits the next state from the decision logic.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      n_lanes_q  <= COUNT_W'(1);
      phase_q    <= PH_IDLE;
      cur_lane_q <= '0;
      active_q   <= COUNT_W'(1);
      fin_q      <= '0;
      bar_vld_q  <= 1'b0;
      bar_kind_q <= OP_DATA;
      bar_seen_q <= '0;
      flags_q    <= '0;
    end else if (cfg_write) begin
      n_lanes_q  <= cfg_n;
      cur_lane_q <= '0;
      active_q   <= cfg_n;
      fin_q      <= '0;
      bar_vld_q  <= 1'b0;
      bar_kind_q <= OP_DATA;
      bar_seen_q <= '0;
    end else if (step) begin
      phase_q    <= phase_d;
      cur_lane_q <= cur_lane_d;
      active_q   <= active_d;
      fin_q      <= fin_d;
      bar_vld_q  <= bar_vld_d;
      bar_kind_q <= bar_kind_d;
      bar_seen_q <= bar_seen_d;
      flags_q    <= flags_d;
    end
  end

  assign out_valid_o     = out_vld_q;
  assign verdict_o       = res_q.verdict;
  assign pass_data_o     = res_q.pass_data;
  assign forward_valid_o = res_q.forward_valid;
  assign forward_kind_o  = res_q.forward_kind;
  assign decoder_reset_o = res_q.decoder_reset;
  assign stream_state_o  = res_q.stream_state;
  assign fault_o         = res_q.fault;

endmodule

// ----- bench/tb_stripe_lane_reassembly_barrier_core.sv -----
// Self-checking testbench for the stripe lane reassembly barrier core.
`timescale 1ns / 100ps

module tb_stripe_lane_reassembly_barrier_core;
  import slrb_pkg::*;

  // The longest quiet stretch is the deliberate output hold-off; the limit leaves ample margin.
  localparam int unsigned QUIET_LIMIT = 2000;
  localparam int unsigned HOLD_CYCLES = 300;
  localparam int unsigned LANES_MAX   = 64;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  logic               cfg_valid_i = 1'b0;
  logic               cfg_ready_o;
  logic [COUNT_W-1:0] cfg_lane_count_i = '0;

  logic              in_valid_i = 1'b0;
  logic              in_ready_o;
  logic [LANE_W-1:0] lane_index_i = '0;
  logic [OP_W-1:0]   opcode_i = OP_DATA;
  logic              end_of_stripe_i = 1'b0;
  logic              from_file_i = 1'b0;
  logic              compressed_i = 1'b0;
  logic              frame_open_i = 1'b0;

  logic              out_valid_o;
  logic              out_ready_i = 1'b0;
  logic [VERD_W-1:0] verdict_o;
  logic              pass_data_o;
  logic              forward_valid_o;
  logic [OP_W-1:0]   forward_kind_o;
  logic              decoder_reset_o;
  logic [PH_W-1:0]   stream_state_o;
  logic              fault_o;

  stripe_lane_reassembly_barrier_core u_top (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_valid_i      (cfg_valid_i),
    .cfg_ready_o      (cfg_ready_o),
    .cfg_lane_count_i (cfg_lane_count_i),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .lane_index_i     (lane_index_i),
    .opcode_i         (opcode_i),
    .end_of_stripe_i  (end_of_stripe_i),
    .from_file_i      (from_file_i),
    .compressed_i     (compressed_i),
    .frame_open_i     (frame_open_i),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .verdict_o        (verdict_o),
    .pass_data_o      (pass_data_o),
    .forward_valid_o  (forward_valid_o),
    .forward_kind_o   (forward_kind_o),
    .decoder_reset_o  (decoder_reset_o),
    .stream_state_o   (stream_state_o),
    .fault_o          (fault_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Fragments waiting to be offered, and the verdicts that accepted fragments are owed.
  slrb_item_t   fragments_pending[$];
  slrb_result_t verdicts_due[$];

  int unsigned mismatches  = 0;
  int unsigned items_built = 0;
  int unsigned tx_idle_pct = 0;
  int unsigned rx_idle_pct = 0;
  int unsigned hold_asks   = 0;
  int unsigned hold_served = 0;
  int unsigned hold_left   = 0;
  int unsigned quiet_count = 0;

  // Own copy of the block's state, advanced once per accepted fragment transfer.
  logic [COUNT_W-1:0] st_count;
  logic [PH_W-1:0]    st_phase;
  logic [LANE_W-1:0]  st_cur;
  logic [COUNT_W-1:0] st_active;
  logic [63:0]        st_fin;
  logic               st_bar_valid;
  logic [OP_W-1:0]    st_bar_kind;
  logic [63:0]        st_bar_seen;
  logic [FLAG_W-1:0]  st_flags;
  slrb_result_t       verdict_now;

  // The lane count in force is the register clamped to one up to the lane maximum.
  function automatic logic [COUNT_W-1:0] lanes_in_use();
    if (st_count < 1) return 7'd1;
    if (st_count > LANES_MAX) return 7'(LANES_MAX);
    return st_count;
  endfunction

  function automatic logic [63:0] lane_mask(input logic [COUNT_W-1:0] n);
    return (n >= 64) ? '1 : ((64'd1 << n) - 64'd1);
  endfunction

  // Steps round robin to the next lane not yet finished. If every lane has finished, the
  // rotation goes all the way round and stays where it was.
  function automatic int next_open_lane(input int cur, input int act, input logic [63:0] fin);
    int a;
    int c;
    logic found;
    a = (act < 1) ? 1 : ((act > 64) ? 64 : act);
    c = cur;
    found = 1'b0;
    for (int i = 0; i < a; i++) begin
      if (!found) begin
        c = (c + 1) % a;
        found = !fin[c];
      end
    end
    return c;
  endfunction

  task automatic reload_rotation(input logic [COUNT_W-1:0] cnt);
    st_active = cnt;
    st_cur = '0;
    st_fin = '0;
  endtask

  task automatic clear_barrier();
    st_bar_valid = 1'b0;
    st_bar_kind = OP_DATA;
    st_bar_seen = '0;
  endtask

  task automatic load_lane_count(input logic [COUNT_W-1:0] v);
    st_count = v;
    reload_rotation(lanes_in_use());
    clear_barrier();
  endtask

  task automatic publish(input logic [OP_W-1:0] kind);
    verdict_now.forward_valid = 1'b1;
    verdict_now.forward_kind = kind;
  endtask

  // Stream state machine for a control kind that has cleared the barrier or bypasses it.
  task automatic apply_control(input logic [OP_W-1:0] op, input logic ff, input logic comp);
    if (op != OP_META) verdict_now.decoder_reset = 1'b1;
    if (st_phase != PH_ERROR || op == OP_FAIL) begin
      case (op) inside
        OP_META: publish(op);
        OP_INIT_FULL, OP_INIT_INCR: begin
          if (st_phase != PH_IDLE) begin
            verdict_now.fault = 1'b1;
          end else begin
            st_phase = PH_PROC;
            st_flags = '0;
            st_flags[FL_FULL] = (op == OP_INIT_FULL);
            st_flags[FL_ZSTD] = comp;
            reload_rotation(ff ? lanes_in_use() : 7'd1);
            publish(op);
          end
        end
        OP_FINI: begin
          if (st_phase != PH_PROC) begin
            verdict_now.fault = 1'b1;
          end else if (st_flags[FL_ZSTD] && st_flags[FL_MID]) begin
            // A finish with a compressed frame still open becomes an error downstream.
            st_phase = PH_ERROR;
            publish(OP_ERROR);
          end else begin
            st_phase = PH_FINISHING;
            publish(op);
          end
        end
        OP_NEXT, OP_DONE: begin
          if (st_phase != PH_FINISHING) begin
            verdict_now.fault = 1'b1;
          end else begin
            st_phase = PH_IDLE;
            publish(op);
          end
        end
        OP_ERROR: begin
          st_phase = PH_ERROR;
          publish(op);
        end
        OP_FAIL: begin
          st_phase = PH_IDLE;
          reload_rotation(lanes_in_use());
          publish(op);
        end
        OP_SHUTDOWN: begin
          if (st_phase != PH_IDLE) begin
            verdict_now.fault = 1'b1;
          end else begin
            st_phase = PH_SHUTDOWN;
            publish(op);
          end
        end
        default: verdict_now.fault = 1'b1;
      endcase
    end
  endtask

  // Works out the verdict of one accepted fragment and files it as owed.
  task automatic predict_verdict(input slrb_item_t it);
    logic [COUNT_W-1:0] n;
    logic [LANE_W-1:0]  lane;
    logic [OP_W-1:0]    op;
    logic               settled;
    n = lanes_in_use();
    lane = it.lane_index;
    op = it.opcode;
    verdict_now = '0;
    verdict_now.verdict = VERD_CONSUMED;
    settled = 1'b0;

    // After shutdown, unknown opcodes and lanes beyond the count are refused outright.
    if (st_phase == PH_SHUTDOWN || op > OP_SHUTDOWN || {1'b0, lane} >= n) begin
      verdict_now.verdict = VERD_DROPPED;
      verdict_now.fault = 1'b1;
      settled = 1'b1;
    end else if (n != 1) begin
      if (st_phase == PH_ERROR && op != OP_FAIL) begin
        verdict_now.verdict = VERD_DROPPED;
        settled = 1'b1;
      end else if (op != OP_ERROR) begin
        if (st_bar_valid && st_bar_seen[lane]) begin
          verdict_now.verdict = VERD_HELD;
          settled = 1'b1;
        end else if ((op == OP_DATA || op == OP_LOADED) && lane != st_cur) begin
          verdict_now.verdict = VERD_HELD;
          settled = 1'b1;
        end
      end
    end

    if (!settled) begin
      if (op == OP_DATA) begin
        if (st_phase != PH_ERROR) begin
          if (st_phase != PH_PROC || st_fin[lane]) begin
            verdict_now.verdict = VERD_DROPPED;
            verdict_now.fault = 1'b1;
            settled = 1'b1;
          end else begin
            verdict_now.pass_data = 1'b1;
            st_flags[FL_MID] = st_flags[FL_ZSTD] && it.frame_open;
          end
        end
        if (!settled && it.end_of_stripe) st_cur = 6'(next_open_lane(st_cur, st_active, st_fin));
      end else if (op == OP_LOADED) begin
        if ({1'b0, lane} >= st_active) begin
          verdict_now.verdict = VERD_DROPPED;
          verdict_now.fault = 1'b1;
        end else begin
          st_fin[lane] = 1'b1;
          st_cur = 6'(next_open_lane(st_cur, st_active, st_fin));
        end
      end else if (n == 1 || op == OP_ERROR || op == OP_META) begin
        apply_control(op, it.from_file, it.compressed);
      end else begin
        if (!st_bar_valid || op != st_bar_kind) begin
          // Only a fail may displace a barrier that is already open.
          if (st_bar_valid && op != OP_FAIL) begin
            verdict_now.verdict = VERD_DROPPED;
            verdict_now.fault = 1'b1;
            settled = 1'b1;
          end else begin
            clear_barrier();
            st_bar_valid = 1'b1;
            st_bar_kind = op;
          end
        end
        if (!settled) begin
          st_bar_seen[lane] = 1'b1;
          if ((st_bar_seen & lane_mask(n)) == lane_mask(n)) begin
            clear_barrier();
            apply_control(op, it.from_file, it.compressed);
          end
        end
      end
    end
    verdict_now.stream_state = st_phase;
    verdicts_due.push_back(verdict_now);
  endtask

  task automatic queue_item(input int lane, input logic [OP_W-1:0] op, input logic eos,
                            input logic ff, input logic comp, input logic fo);
    slrb_item_t it;
    it.lane_index = 6'(lane);
    it.opcode = op;
    it.end_of_stripe = eos;
    it.from_file = ff;
    it.compressed = comp;
    it.frame_open = fo;
    fragments_pending.push_back(it);
    items_built++;
  endtask

  task automatic queue_noise();
    queue_item($urandom_range(63), 4'($urandom_range(15)), 1'($urandom_range(1)),
               1'($urandom_range(1)), 1'($urandom_range(1)), 1'($urandom_range(1)));
  endtask

  // One control kind from every lane in random order, now and then with a repeat from a lane
  // already seen (held) or a conflicting kind from a lane not yet seen (refused).
  task automatic queue_barrier(input int n, input logic [OP_W-1:0] op, input logic ff,
                               input logic comp);
    int left[$];
    int sent[$];
    int pick;
    int r;
    logic [OP_W-1:0] other;
    other = (op == OP_NEXT) ? OP_DONE : OP_NEXT;
    for (int l = 0; l < n; l++) left.push_back(l);
    while (left.size() != 0) begin
      if (n > 1 && sent.size() != 0) begin
        r = $urandom_range(99);
        if (r < 8) begin
          queue_item(sent[$urandom_range(sent.size() - 1)], op, 1'b0, ff, comp, 1'b0);
        end else if (r < 11 && op != OP_FAIL) begin
          queue_item(left[$urandom_range(left.size() - 1)], other, 1'b0, ff, comp, 1'b0);
        end
      end
      pick = $urandom_range(left.size() - 1);
      sent.push_back(left[pick]);
      queue_item(left[pick], op, 1'($urandom_range(1)), ff, comp, 1'($urandom_range(1)));
      left.delete(pick);
    end
  endtask

  // A well-formed stream: init barrier, round-robin data with load-complete marks and the odd
  // stray fragment, then finish and close, or a fail barrier after an error or mid-frame finish.
  task automatic build_session(input int n);
    logic [OP_W-1:0] init_op;
    logic ff;
    logic comp;
    logic mid;
    logic aborted;
    logic eos;
    logic fo;
    logic [63:0] fin;
    int act;
    int cur;
    int frags;
    int r;
    init_op = $urandom_range(1) ? OP_INIT_FULL : OP_INIT_INCR;
    ff = ($urandom_range(3) != 0);
    comp = 1'($urandom_range(1));
    queue_barrier(n, init_op, ff, comp);
    act = ff ? n : 1;
    cur = 0;
    fin = '0;
    mid = 1'b0;
    aborted = 1'b0;
    frags = $urandom_range(24 + n, 4);
    for (int k = 0; k < frags && !aborted; k++) begin
      r = $urandom_range(99);
      if (r < 8) begin
        queue_noise();
      end else if (r < 12) begin
        queue_item($urandom_range(n - 1), OP_META, 1'($urandom_range(1)), 1'($urandom_range(1)),
                   1'($urandom_range(1)), 1'($urandom_range(1)));
      end else if (r < 16 && (fin & lane_mask(7'(act))) != lane_mask(7'(act))) begin
        queue_item(cur, OP_LOADED, 1'b0, 1'b0, 1'b0, 1'b0);
        fin[cur] = 1'b1;
        cur = next_open_lane(cur, act, fin);
      end else if (r < 18) begin
        queue_item($urandom_range(n - 1), OP_ERROR, 1'b0, 1'b0, 1'b0, 1'b0);
        aborted = 1'b1;
      end else if ((fin & lane_mask(7'(act))) != lane_mask(7'(act))) begin
        eos = ($urandom_range(2) == 0);
        fo = 1'($urandom_range(1));
        queue_item(cur, OP_DATA, eos, 1'($urandom_range(1)), 1'($urandom_range(1)), fo);
        mid = comp && fo;
        if (eos) cur = next_open_lane(cur, act, fin);
      end
    end
    if (!aborted) queue_barrier(n, OP_FINI, 1'b0, 1'b0);
    if (aborted || mid) begin
      queue_barrier(n, OP_FAIL, 1'b0, 1'b0);
    end else begin
      queue_barrier(n, $urandom_range(1) ? OP_NEXT : OP_DONE, 1'b0, 1'b0);
    end
  endtask

  task automatic run_sessions(input int n, input int unsigned until_built);
    while (items_built < until_built) build_session(n);
  endtask

  // Writes the lane count through its own channel; only called with nothing in flight.
  task automatic write_lane_count(input logic [COUNT_W-1:0] v);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_lane_count_i <= v;
    do @(posedge clk_i); while (!cfg_ready_o);
    load_lane_count(v);
    cfg_valid_i <= 1'b0;
    @(negedge clk_i);
  endtask

  // Waits until every queued fragment has been taken and every owed verdict has arrived.
  task automatic await_drain();
    do @(negedge clk_i);
    while (fragments_pending.size() != 0 || in_valid_i || verdicts_due.size() != 0);
  endtask

  task automatic report_field(input string field, input int want, input int got);
    $display("%0t ns: %s expected %0d, actual %0d", $time, field, want, got);
  endtask

  // Driver: offers the oldest pending fragment, holding it steady until its transfer. The
  // verdict is predicted at the very edge of the transfer, so prediction follows the order in
  // which the block accepts fragments.
  always @(posedge clk_i) begin : feed
    logic taken;
    logic offer;
    slrb_item_t nxt;
    if (rst_ni) begin
      taken = in_valid_i && in_ready_o;
      if (taken) begin
        nxt.lane_index = lane_index_i;
        nxt.opcode = opcode_i;
        nxt.end_of_stripe = end_of_stripe_i;
        nxt.from_file = from_file_i;
        nxt.compressed = compressed_i;
        nxt.frame_open = frame_open_i;
        predict_verdict(nxt);
      end
      if (taken || !in_valid_i) begin
        offer = (fragments_pending.size() != 0) && ($urandom_range(99) >= tx_idle_pct);
        if (offer) begin
          nxt = fragments_pending.pop_front();
          lane_index_i <= nxt.lane_index;
          opcode_i <= nxt.opcode;
          end_of_stripe_i <= nxt.end_of_stripe;
          from_file_i <= nxt.from_file;
          compressed_i <= nxt.compressed;
          frame_open_i <= nxt.frame_open;
        end
        in_valid_i <= offer;
      end
    end
  end

  // Monitor: checks every verdict transfer against the oldest owed verdict, then decides
  // whether to stall. A hold-off request makes it refuse for a long stretch so that the
  // block backs up and stops taking fragments.
  always @(posedge clk_i) begin : observe
    slrb_result_t got;
    slrb_result_t want;
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        got.verdict = verdict_o;
        got.pass_data = pass_data_o;
        got.forward_valid = forward_valid_o;
        got.forward_kind = forward_kind_o;
        got.decoder_reset = decoder_reset_o;
        got.stream_state = stream_state_o;
        got.fault = fault_o;
        if (verdicts_due.size() == 0) begin
          $display("%0t ns: verdict transfer expected none, actual %h", $time, got);
          mismatches++;
        end else begin
          want = verdicts_due.pop_front();
          if (got !== want) begin
            mismatches++;
            if (got.verdict !== want.verdict)
              report_field("verdict", want.verdict, got.verdict);
            if (got.pass_data !== want.pass_data)
              report_field("pass_data", want.pass_data, got.pass_data);
            if (got.forward_valid !== want.forward_valid)
              report_field("forward_valid", want.forward_valid, got.forward_valid);
            if (got.forward_kind !== want.forward_kind)
              report_field("forward_kind", want.forward_kind, got.forward_kind);
            if (got.decoder_reset !== want.decoder_reset)
              report_field("decoder_reset", want.decoder_reset, got.decoder_reset);
            if (got.stream_state !== want.stream_state)
              report_field("stream_state", want.stream_state, got.stream_state);
            if (got.fault !== want.fault)
              report_field("fault", want.fault, got.fault);
          end
        end
      end
      if (hold_asks != hold_served) begin
        hold_served = hold_asks;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= ($urandom_range(99) >= rx_idle_pct);
      end
    end
  end

  // Watchdog: any transfer on any channel counts as progress.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) ||
          (cfg_valid_i && cfg_ready_o)) begin
        quiet_count <= 0;
      end else if (quiet_count >= QUIET_LIMIT) begin
        $display("%0t ns: no transfer for %0d cycles", $time, QUIET_LIMIT);
        $display("FAILED: results differ");
        $finish;
      end else begin
        quiet_count <= quiet_count + 1;
      end
    end
  end

  initial begin
    st_count = 7'd1;
    st_phase = PH_IDLE;
    st_flags = '0;
    reload_rotation(7'd1);
    clear_barrier();

    tx_idle_pct = 28;
    rx_idle_pct = 46;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed, single lane straight out of reset: refusals, both inits, a finish in
    // mid-frame turning into an error, the error phase itself, and the normal close.
    queue_item(0, OP_DATA, 1'b0, 1'b0, 1'b0, 1'b0);
    queue_item(1, OP_INIT_FULL, 1'b0, 1'b1, 1'b1, 1'b0);
    queue_item(0, OP_SHUTDOWN + 4'd1, 1'b0, 1'b0, 1'b0, 1'b0);
    queue_item(63, 4'hF, 1'b1, 1'b1, 1'b1, 1'b1);
    queue_item(0, OP_INIT_FULL, 1'b0, 1'b1, 1'b1, 1'b0);
    queue_item(0, OP_INIT_INCR, 1'b0, 1'b1, 1'b0, 1'b0);
    queue_item(0, OP_DATA, 1'b0, 1'b0, 1'b0, 1'b1);
    queue_item(0, OP_META, 1'b0, 1'b0, 1'b0, 1'b0);
    queue_item(0, OP_FINI, 1'b0, 1'b0, 1'b0, 1'b0);
    queue_item(0, OP_DATA, 1'b1, 1'b0, 1'b0, 1'b1);
    queue_item(0, OP_NEXT, 1'b0, 1'b0, 1'b0, 1'b0);
    queue_item(0, OP_FAIL, 1'b0, 1'b0, 1'b0, 1'b0);
    queue_item(0, OP_INIT_INCR, 1'b0, 1'b0, 1'b0, 1'b0);
    queue_item(0, OP_DATA, 1'b1, 1'b0, 1'b0, 1'b1);
    queue_item(0, OP_LOADED, 1'b0, 1'b0, 1'b0, 1'b0);
    queue_item(0, OP_DATA, 1'b0, 1'b0, 1'b0, 1'b0);
    queue_item(0, OP_FINI, 1'b0, 1'b0, 1'b0, 1'b0);
    queue_item(0, OP_DONE, 1'b0, 1'b0, 1'b0, 1'b0);
    queue_item(0, OP_NEXT, 1'b0, 1'b0, 1'b0, 1'b0);
    queue_item(0, OP_ERROR, 1'b0, 1'b0, 1'b0, 1'b0);
    queue_item(0, OP_FAIL, 1'b0, 1'b0, 1'b0, 1'b0);
    await_drain();

    // Two lanes: a held repeat, a conflicting kind refused, a fail displacing the open
    // barrier, data held off its turn, and the error bypass with everything else dropped.
    write_lane_count(7'd2);
    queue_item(0, OP_INIT_FULL, 1'b0, 1'b1, 1'b0, 1'b0);
    queue_item(0, OP_INIT_FULL, 1'b0, 1'b1, 1'b0, 1'b0);
    queue_item(1, OP_FINI, 1'b0, 1'b0, 1'b0, 1'b0);
    queue_item(1, OP_FAIL, 1'b0, 1'b0, 1'b0, 1'b0);
    queue_item(0, OP_FAIL, 1'b0, 1'b0, 1'b0, 1'b0);
    queue_item(1, OP_DATA, 1'b0, 1'b0, 1'b0, 1'b0);
    queue_item(0, OP_ERROR, 1'b0, 1'b0, 1'b0, 1'b0);
    queue_item(1, OP_DATA, 1'b0, 1'b0, 1'b0, 1'b0);
    queue_item(1, OP_FAIL, 1'b0, 1'b0, 1'b0, 1'b0);
    queue_item(0, OP_FAIL, 1'b0, 1'b0, 1'b0, 1'b0);
    run_sessions(2, 150);
    await_drain();

    // A zero count clamps to a single lane, where controls act without a barrier.
    write_lane_count(7'd0);
    run_sessions(1, 270);
    await_drain();

    // Three lanes, with a long receiver hold-off early on to back the block up.
    write_lane_count(7'd3);
    run_sessions(3, 470);
    hold_asks++;
    await_drain();

    // The other idling mix, starting at the top of the register, which clamps to the maximum.
    tx_idle_pct = 46;
    rx_idle_pct = 28;
    write_lane_count(7'h7F);
    run_sessions(LANES_MAX, 700);
    await_drain();

    write_lane_count(7'($urandom_range(12, 4)));
    run_sessions(int'(lanes_in_use()), 900);
    await_drain();

    // No idling from here on: the exact maximum with stray traffic, then sessions, then a
    // shutdown after which everything is refused.
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    write_lane_count(7'(LANES_MAX));
    repeat (40) queue_noise();
    await_drain();

    write_lane_count(7'($urandom_range(8, 1)));
    run_sessions(int'(lanes_in_use()), 1130);
    queue_barrier(int'(lanes_in_use()), OP_SHUTDOWN, 1'b0, 1'b0);
    repeat (8) queue_noise();
    await_drain();

    repeat (8) @(negedge clk_i);
    if (mismatches == 0 && verdicts_due.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
